>>> src/vpet_pkg.sv
// shared types and constants for the volumetric power energy terms block
// no dependencies
package vpet_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CBRT,
    ST_POW,
    ST_ENERGY,
    ST_RECIP,
    ST_MUL,
    ST_ROUND,
    ST_DONE
  } state_e;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXPONENT  = 2'd1,
    STAT_ZERO      = 2'd2,
    STAT_SATURATED = 2'd3
  } status_e;

  // micro operations of the derivative phase
  typedef enum logic [3:0] {
    OP_INV2   = 4'd0,
    OP_INV4   = 4'd1,
    OP_INV5   = 4'd2,
    OP_K1A    = 4'd3,
    OP_K1     = 4'd4,
    OP_FIRST  = 4'd5,
    OP_AA     = 4'd6,
    OP_A      = 4'd7,
    OP_BA     = 4'd8,
    OP_B      = 4'd9,
    OP_S2     = 4'd10,
    OP_SECOND = 4'd11
  } op_e;

  // register indexes
  localparam logic REG_COEF = 1'b0;
  localparam logic REG_EXPO = 1'b1;

  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // reciprocal multipliers for exact unsigned 64-bit division by 3 and 9
  localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [6:0]  DIV3_SHIFT = 7'd65;
  localparam logic [63:0] DIV9_MAGIC = 64'hE38E_38E3_8E38_E38F;
  localparam logic [6:0]  DIV9_SHIFT = 7'd67;

  localparam int CBRT_STEPS = 40;
  localparam int DIV_STEPS  = 65;

endpackage

>>> src/volumetric_power_energy_terms.sv
// from acceptance to result valid: cube root (40 root steps), the powers and the energy
// product; reciprocal (65 steps) and derivative products only if d >= 2 and invariant != 0
// throughput: one request at a time, the next accepted in the cycle after the result is
// registered; the shared 32x32 multiplier (four passes a product) and the divider set it
// reset: coefficient 1.0, exponent 2, sequencer idle, no result pending
// uses vpet_pkg
module volumetric_power_energy_terms #(
  parameter int INPUT_FRAC_BITS  = 28,
  parameter int OUTPUT_FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        volume_invariant_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] energy_term_o,
  output logic signed [63:0] first_derivative_o,
  output logic signed [63:0] second_derivative_o,
  output logic [1:0]         status_o
);

  localparam int CS = 48 - OUTPUT_FRAC_BITS;
  localparam int NSHIFT = 96 - INPUT_FRAC_BITS;

  // configuration registers
  logic signed [31:0] coef_q;
  logic [3:0]         expo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= 32'sd65536;
      expo_q <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vpet_pkg::REG_COEF: coef_q <= cfg_wdata_i;
        vpet_pkg::REG_EXPO: expo_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  vpet_pkg::state_e state_q, state_d;
  logic [6:0]   icnt_q;
  logic [3:0]   pcnt_q;
  logic [3:0]   op_q;
  logic [2:0]   mcnt_q;
  logic         zero_q, sat_q;

  // cube root datapath
  logic [119:0] nreg_q;
  logic [87:0]  crem_q;
  logic [79:0]  ysq_q;
  logic [39:0]  y_q;

  // value registers
  logic signed [63:0] t_q, p_q, tp1_q, tp2_q, energy_q;
  logic signed [63:0] inv_q, inv2_q, inv4_q, inv5_q, tmp_q, k1_q, a_q, b_q, s2_q;
  logic signed [63:0] first_q, second_q;

  // divider
  logic [64:0] dend_q;
  logic [63:0] ddiv_q, drem_q, dq_q;

  // multiplier accumulator
  logic [127:0] acc_q;

  // output register
  logic               ovalid_q;
  logic signed [63:0] oen_q, ofi_q, ose_q;
  logic [1:0]         ost_q;

  logic in_acc, out_free, cbrt_last, div_last, mul_fin;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign cbrt_last = (icnt_q == 7'(vpet_pkg::CBRT_STEPS - 1));
  assign div_last  = (icnt_q == 7'(vpet_pkg::DIV_STEPS - 1));
  assign mul_fin   = (mcnt_q == 3'd4);

  // cube root step
  logic [87:0] rem_s, trial;
  logic        take;
  always_comb begin
    rem_s = {crem_q[84:0], nreg_q[119:117]};
    trial = {5'b0, ysq_q, 3'b0} + {6'b0, ysq_q, 2'b0} + {45'b0, y_q, 3'b0}
            - {47'b0, y_q, 1'b0} + 88'd1;
    take  = (rem_s >= trial);
  end

  // saturating b - a for the second derivative
  logic signed [63:0] nega, addv;
  logic signed [64:0] addw;
  logic               addsat;
  always_comb begin
    nega = (a_q == vpet_pkg::S64_MIN) ? vpet_pkg::S64_MAX : -a_q;
    addw = {b_q[63], b_q} + {nega[63], nega};
    addsat = (addw[64] != addw[63]);
    addv = addsat ? (addw[64] ? vpet_pkg::S64_MIN : vpet_pkg::S64_MAX) : addw[63:0];
  end

  // rounding division operand
  logic [63:0] uabs;
  assign uabs = tmp_q[63] ? 64'(-tmp_q) : 64'(tmp_q);

  // multiplier operand select
  logic signed [63:0] ma, mb, c64;
  logic [6:0]         ms;
  logic               mu;
  assign c64 = {{32{coef_q[31]}}, coef_q};
  always_comb begin
    ma = p_q;
    mb = t_q;
    ms = 7'd32;
    mu = 1'b0;
    case (state_q)
      vpet_pkg::ST_ENERGY: begin
        ma = c64; mb = p_q; ms = 7'(CS);
      end
      vpet_pkg::ST_MUL: begin
        case (op_q)
          vpet_pkg::OP_INV2: begin ma = inv_q; mb = inv_q; end
          vpet_pkg::OP_INV4: begin ma = inv2_q; mb = inv2_q; end
          vpet_pkg::OP_INV5: begin ma = inv4_q; mb = inv_q; end
          vpet_pkg::OP_K1A: begin ma = tp1_q; mb = inv2_q; end
          vpet_pkg::OP_K1: begin ma = tmp_q; mb = {60'b0, expo_q}; ms = 7'd0; end
          vpet_pkg::OP_FIRST: begin ma = c64; mb = k1_q; ms = 7'(CS); end
          vpet_pkg::OP_AA: begin ma = tp1_q; mb = inv5_q; end
          vpet_pkg::OP_A: begin ma = tmp_q; mb = 64'sd2; ms = 7'd0; end
          vpet_pkg::OP_BA: begin ma = tp2_q; mb = inv4_q; end
          vpet_pkg::OP_B: begin ma = tmp_q; mb = {60'b0, expo_q - 4'd1}; ms = 7'd0; end
          vpet_pkg::OP_S2: begin ma = addv; mb = {60'b0, expo_q}; ms = 7'd0; end
          vpet_pkg::OP_SECOND: begin ma = c64; mb = s2_q; ms = 7'(CS); end
          default: ;
        endcase
      end
      // divide the magnitude by 3 or 9 as an unsigned multiply by the reciprocal, rounded to nearest
      vpet_pkg::ST_ROUND: begin
        mu = 1'b1;
        if (op_q == vpet_pkg::OP_FIRST) begin
          ma = uabs + 64'd1; mb = vpet_pkg::DIV3_MAGIC; ms = vpet_pkg::DIV3_SHIFT;
        end else begin
          ma = uabs + 64'd4; mb = vpet_pkg::DIV9_MAGIC; ms = vpet_pkg::DIV9_SHIFT;
        end
      end
      default: ;
    endcase
  end

  // multiplier: one 32x32 partial product a cycle, then round and clamp
  logic         mneg;
  logic [63:0]  ua, ub, pp, limit;
  logic [31:0]  ah, bh;
  logic [127:0] acc_d, sum, shv;
  logic signed [63:0] mres;
  logic         msat;
  always_comb begin
    mneg  = !mu && (ma[63] ^ mb[63]);
    ua    = (!mu && ma[63]) ? 64'(-ma) : 64'(ma);
    ub    = (!mu && mb[63]) ? 64'(-mb) : 64'(mb);
    ah    = mcnt_q[0] ? ua[63:32] : ua[31:0];
    bh    = mcnt_q[1] ? ub[63:32] : ub[31:0];
    pp    = {32'b0, ah} * {32'b0, bh};
    acc_d = ((mcnt_q == 3'd0) ? 128'd0 : acc_q)
            + ({64'b0, pp} << {({1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]}), 5'b0});
    sum   = acc_q + ((!mu && ms != 7'd0) ? (128'd1 << (ms - 7'd1)) : 128'd0);
    shv   = sum >> ms;
    limit = mneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    msat  = (shv[127:64] != 64'd0) || (shv[63:0] > limit);
    if (msat) mres = mneg ? vpet_pkg::S64_MIN : vpet_pkg::S64_MAX;
    else      mres = mneg ? -$signed(shv[63:0]) : $signed(shv[63:0]);
  end

  // divider step
  logic [64:0] drs;
  logic        dbit;
  always_comb begin
    drs  = {drem_q, dend_q[64]};
    dbit = (drs >= {1'b0, ddiv_q});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vpet_pkg::ST_IDLE: if (in_acc) state_d = vpet_pkg::ST_CBRT;
      vpet_pkg::ST_CBRT: if (cbrt_last) state_d = vpet_pkg::ST_POW;
      vpet_pkg::ST_POW: if (pcnt_q == expo_q) state_d = vpet_pkg::ST_ENERGY;
      vpet_pkg::ST_ENERGY: begin
        if (mul_fin)
          state_d = (zero_q || expo_q < 4'd2) ? vpet_pkg::ST_DONE : vpet_pkg::ST_RECIP;
      end
      vpet_pkg::ST_RECIP: if (div_last) state_d = vpet_pkg::ST_MUL;
      vpet_pkg::ST_MUL: begin
        if (mul_fin && (op_q == vpet_pkg::OP_FIRST || op_q == vpet_pkg::OP_SECOND))
          state_d = vpet_pkg::ST_ROUND;
      end
      vpet_pkg::ST_ROUND: begin
        if (mul_fin)
          state_d = (op_q == vpet_pkg::OP_SECOND) ? vpet_pkg::ST_DONE : vpet_pkg::ST_MUL;
      end
      vpet_pkg::ST_DONE: if (out_free) state_d = vpet_pkg::ST_IDLE;
      default: state_d = vpet_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o          = (state_q != vpet_pkg::ST_IDLE);
    out_valid_o         = ovalid_q;
    energy_term_o       = oen_q;
    first_derivative_o  = ofi_q;
    second_derivative_o = ose_q;
    status_o            = ost_q;
  end

  // control registers
  logic mul_active;
  assign mul_active = (state_q == vpet_pkg::ST_ENERGY) || (state_q == vpet_pkg::ST_MUL)
                      || (state_q == vpet_pkg::ST_ROUND)
                      || ((state_q == vpet_pkg::ST_POW) && (pcnt_q != expo_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vpet_pkg::ST_IDLE;
      icnt_q   <= '0;
      pcnt_q   <= '0;
      op_q     <= '0;
      mcnt_q   <= '0;
      zero_q   <= 1'b0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        icnt_q <= '0;
        pcnt_q <= '0;
        op_q   <= vpet_pkg::OP_INV2;
        mcnt_q <= '0;
        zero_q <= (volume_invariant_i == 32'd0);
        sat_q  <= 1'b0;
      end
      if (state_q == vpet_pkg::ST_CBRT || state_q == vpet_pkg::ST_RECIP)
        icnt_q <= (cbrt_last && state_q == vpet_pkg::ST_CBRT) || div_last ? 7'd0
                  : icnt_q + 7'd1;
      if (mul_active) begin
        mcnt_q <= mul_fin ? 3'd0 : mcnt_q + 3'd1;
        if (mul_fin) begin
          sat_q <= sat_q | msat
                   | (state_q == vpet_pkg::ST_MUL && op_q == vpet_pkg::OP_S2 && addsat);
          if (state_q == vpet_pkg::ST_POW) pcnt_q <= pcnt_q + 4'd1;
          if (state_q == vpet_pkg::ST_MUL && op_q != vpet_pkg::OP_FIRST
              && op_q != vpet_pkg::OP_SECOND)
            op_q <= op_q + 4'd1;
        end
      end
      if (state_q == vpet_pkg::ST_ROUND && mul_fin && op_q == vpet_pkg::OP_FIRST)
        op_q <= vpet_pkg::OP_AA;
      if (state_q == vpet_pkg::ST_DONE && out_free) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      nreg_q <= 120'(volume_invariant_i) << NSHIFT;
      crem_q <= '0;
      ysq_q  <= '0;
      y_q    <= '0;
      p_q    <= vpet_pkg::Q_ONE;
      tp1_q  <= vpet_pkg::Q_ONE;
      tp2_q  <= vpet_pkg::Q_ONE;
      first_q  <= '0;
      second_q <= '0;
    end
    // cube root, three radicand bits a step
    if (state_q == vpet_pkg::ST_CBRT) begin
      nreg_q <= {nreg_q[116:0], 3'b0};
      if (take) begin
        crem_q <= rem_s - trial;
        y_q    <= {y_q[38:0], 1'b1};
        ysq_q  <= {ysq_q[77:0], 2'b0} + {38'b0, y_q, 2'b0} + 80'd1;
      end else begin
        crem_q <= rem_s;
        y_q    <= {y_q[38:0], 1'b0};
        ysq_q  <= {ysq_q[77:0], 2'b0};
      end
      if (cbrt_last)
        t_q <= $signed({24'b0, take ? {y_q[38:0], 1'b1} : {y_q[38:0], 1'b0}})
               - vpet_pkg::Q_ONE;
    end
    if (mul_active) acc_q <= acc_d;
    // product results
    if (mul_active && mul_fin) begin
      case (state_q)
        vpet_pkg::ST_POW: begin
          p_q <= mres;
          if (pcnt_q + 4'd1 == expo_q - 4'd1) tp1_q <= mres;
          if (pcnt_q + 4'd1 == expo_q - 4'd2) tp2_q <= mres;
        end
        vpet_pkg::ST_ENERGY: begin
          energy_q <= mres;
          dend_q   <= {1'b1, 64'b0};
          ddiv_q   <= {24'b0, y_q};
          drem_q   <= '0;
        end
        vpet_pkg::ST_MUL: begin
          case (op_q)
            vpet_pkg::OP_INV2: inv2_q <= mres;
            vpet_pkg::OP_INV4: inv4_q <= mres;
            vpet_pkg::OP_INV5: inv5_q <= mres;
            vpet_pkg::OP_K1: k1_q <= mres;
            vpet_pkg::OP_A: a_q <= mres;
            vpet_pkg::OP_B: b_q <= mres;
            vpet_pkg::OP_S2: s2_q <= mres;
            default: tmp_q <= mres;
          endcase
        end
        // quotient magnitude, sign of the dividend restored
        vpet_pkg::ST_ROUND: begin
          if (op_q == vpet_pkg::OP_FIRST)
            first_q <= tmp_q[63] ? -mres : mres;
          else
            second_q <= tmp_q[63] ? -mres : mres;
        end
        default: ;
      endcase
    end
    // restoring divider for the reciprocal, one quotient bit a step
    if (state_q == vpet_pkg::ST_RECIP) begin
      dend_q <= {dend_q[63:0], 1'b0};
      drem_q <= dbit ? 64'(drs - {1'b0, ddiv_q}) : drs[63:0];
      dq_q   <= {dq_q[62:0], dbit};
      if (div_last) inv_q <= $signed({dq_q[62:0], dbit});
    end
    // result hand-off
    if (state_q == vpet_pkg::ST_DONE && out_free) begin
      oen_q <= energy_q;
      ofi_q <= first_q;
      ose_q <= second_q;
      if (zero_q)             ost_q <= vpet_pkg::STAT_ZERO;
      else if (expo_q < 4'd2) ost_q <= vpet_pkg::STAT_EXPONENT;
      else if (sat_q)         ost_q <= vpet_pkg::STAT_SATURATED;
      else                    ost_q <= vpet_pkg::STAT_OK;
    end
  end

  // checks
  a_zero_derivs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == vpet_pkg::STAT_ZERO || status_o == vpet_pkg::STAT_EXPONENT)
    |-> first_derivative_o == 64'sd0 && second_derivative_o == 64'sd0)
    else $error("derivatives not cleared for error status");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == vpet_pkg::ST_CBRT)
    else $error("accepted request did not start the cube root");
  a_mcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= 3'd4)
    else $error("multiplier step counter out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q)
    else $error("pending result dropped while stalled");

endmodule
